FILE: rtl/core/scuv_pkg.sv
// Shared constants, widths and helper functions for the sphere/cylinder UV map unit.
// No dependencies; used by scuv_cordic, scuv_isqrt and sphere_cylinder_uv_map_unit.

package scuv_pkg;

    // Input fixed-point format and cylindrical rescale shifts.
    localparam int FRAC_BITS = 16;
    localparam int CYL_RS = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int CYL_LS = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    // CORDIC datapath: operands up to 2^47 grow by the CORDIC gain.
    localparam int CORDIC_STAGES = 24;
    localparam int CW = 52;
    localparam int AW = 34;
    localparam int PRE_SHIFT = 16;

    // Square root: one result bit per stage.
    localparam int SQRT_STAGES = 32;

    // Pipeline alignment between the u and v paths.
    localparam int U_ALIGN = 2 + SQRT_STAGES;
    localparam int SIDE_DELAY = 2 + SQRT_STAGES + CORDIC_STAGES;

    // Mode register codes.
    localparam logic MODE_SPHERE = 1'b0;
    localparam logic MODE_CYL = 1'b1;

    // Elementary angles atan(2^-i) in units of 2^-32 turn.
    function automatic logic signed [AW-1:0] atan_turn(input int i);
        case (i)
            0:  return AW'(536870912);
            1:  return AW'(316933406);
            2:  return AW'(167458907);
            3:  return AW'(85004756);
            4:  return AW'(42667331);
            5:  return AW'(21354465);
            6:  return AW'(10679838);
            7:  return AW'(5340245);
            8:  return AW'(2670163);
            9:  return AW'(1335087);
            10: return AW'(667544);
            11: return AW'(333772);
            12: return AW'(166886);
            13: return AW'(83443);
            14: return AW'(41722);
            15: return AW'(20861);
            16: return AW'(10430);
            17: return AW'(5215);
            18: return AW'(2608);
            19: return AW'(1304);
            20: return AW'(652);
            21: return AW'(326);
            22: return AW'(163);
            23: return AW'(81);
            default: return '0;
        endcase
    endfunction

    // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Left shift that brings a nonzero magnitude up to at least 2^30.
    function automatic logic [4:0] norm_shift(input logic [31:0] m);
        logic [4:0] msb;
        msb = '0;
        for (int k = 0; k < 31; k++) begin
            if (m[k]) begin
                msb = 5'(k);
            end
        end
        if (m == '0 || m[31] || m[30]) begin
            return '0;
        end
        return 5'(30) - msb;
    endfunction

endpackage

FILE: rtl/core/scuv_cordic.sv
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
// Depends on scuv_pkg for widths and the elementary angle table.

module scuv_cordic (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [scuv_pkg::CW-1:0]     a_in,
    input  logic signed [scuv_pkg::CW-1:0]     b_in,
    output logic signed [scuv_pkg::AW-1:0]     angle
);

    localparam int N = scuv_pkg::CORDIC_STAGES;

    logic signed [scuv_pkg::CW-1:0] a_reg [N-1];
    logic signed [scuv_pkg::CW-1:0] b_reg [N-1];
    logic signed [scuv_pkg::AW-1:0] ang_reg [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [scuv_pkg::CW-1:0] a_prev;
        logic signed [scuv_pkg::CW-1:0] b_prev;
        logic signed [scuv_pkg::AW-1:0] g_prev;

        // Select the previous stage, or the pipeline input for the first one.
        if (i == 0) begin : g_first
            assign a_prev = a_in;
            assign b_prev = b_in;
            assign g_prev = '0;
        end else begin : g_next
            assign a_prev = a_reg[i-1];
            assign b_prev = b_reg[i-1];
            assign g_prev = ang_reg[i-1];
        end

        // Angle accumulator: rotate toward b = 0.
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!b_prev[scuv_pkg::CW-1]) begin
                    ang_reg[i] <= g_prev + scuv_pkg::atan_turn(i);
                end else begin
                    ang_reg[i] <= g_prev - scuv_pkg::atan_turn(i);
                end
            end
        end

        // Vector update; the last stage only needs the angle.
        if (i < N - 1) begin : g_vec
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!b_prev[scuv_pkg::CW-1]) begin
                        a_reg[i] <= a_prev + (b_prev >>> i);
                        b_reg[i] <= b_prev - (a_prev >>> i);
                    end else begin
                        a_reg[i] <= a_prev - (b_prev >>> i);
                        b_reg[i] <= b_prev + (a_prev >>> i);
                    end
                end
            end
        end
    end

    assign angle = ang_reg[N-1];

endmodule

FILE: rtl/core/scuv_isqrt.sv
// Pipelined integer square root, floor(sqrt(n)) of a 64-bit value, one bit per stage.
// Depends on scuv_pkg for the stage count.

module scuv_isqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] n_in,
    output logic [31:0] root
);

    localparam int N = scuv_pkg::SQRT_STAGES;

    logic [31:0] root_reg [N];
    logic [63:0] rem_reg  [N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int BIT = N - 1 - k;
        logic [31:0] root_prev;
        logic [63:0] rem_prev;
        logic [65:0] trial;
        logic        take;

        if (k == 0) begin : g_first
            assign root_prev = '0;
            assign rem_prev  = n_in;
        end else begin : g_next
            assign root_prev = root_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
        end

        // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b); keep the bit if it fits the remainder.
        always_comb begin
            trial = ({34'b0, root_prev} << (BIT + 1)) + (66'd1 << (2 * BIT));
            take  = {2'b0, rem_prev} >= trial;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= root_prev | (32'(take) << BIT);
            end
        end

        // The remainder is not needed after the last bit.
        if (k < N - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? rem_prev - trial[63:0] : rem_prev;
                end
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

FILE: rtl/core/sphere_cylinder_uv_map_unit.sv
// Top level of the sphere/cylinder UV map unit: front end, alignment and output stage.
// Depends on scuv_pkg, scuv_cordic (u and v angles) and scuv_isqrt (horizontal radius).
//
//  Channel  Direction  Payload
//  s_       in         tdata[95:0]: x_coord[31:0], y_coord[63:32], z_coord[95:64]
//  m_       out        tdata[39:0]: u_coord[15:0], v_coord[33:16], zero pad;
//                      tuser[0]: degenerate
//  cfg_     in         wr_en, wr_data[0]: map_mode
//
// One point enters per cycle unless the output stalls. The path holds 62 register stages:
// three front-end stages, two for the squared radius, 32 square-root stages and 24 CORDIC
// stages, and the output register.
// Reset clears all valid bits and map_mode.
// A stall at the output freezes the whole pipeline; s_tready is high whenever the
// output register is empty or being taken.

module sphere_cylinder_uv_map_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // x_coord, y_coord, z_coord from bit 0 up
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // u_coord, v_coord, zero pad from bit 0 up
    output logic [0:0]  m_tuser    // degenerate
);

    localparam int CW = scuv_pkg::CW;
    localparam int AW = scuv_pkg::AW;
    localparam int SD = scuv_pkg::SIDE_DELAY;
    localparam int UA = scuv_pkg::U_ALIGN;
    localparam int SQ = scuv_pkg::SQRT_STAGES;

    // Per-item flags that travel beside the arithmetic.
    typedef struct packed {
        logic               mode;
        logic               origin;
        logic               x_zero;
        logic               z_neg;
        logic signed [17:0] cyl_v;
    } side_t;

    logic en;
    logic map_mode_reg;

    // Front-end registers.
    logic               v1_reg, v2_reg, v3_reg;
    logic signed [31:0] x1_reg, y1_reg, z1_reg;
    logic               mode1_reg;
    logic signed [31:0] x2_reg, y2_reg, z2_reg;
    logic [4:0]         su2_reg, sv2_reg;
    side_t              side2_reg, side3_reg;
    logic signed [CW-1:0] ua3_reg, ub3_reg, yb3_reg, yb4_reg, yb5_reg;
    logic signed [31:0] xn3_reg, zn3_reg;
    logic [63:0]        sqx4_reg, sqz4_reg, n5_reg;

    // Alignment lines.
    logic               vpipe_reg [SD];
    side_t              side_reg  [SD];
    logic signed [AW-1:0] ualign_reg [UA];
    logic signed [CW-1:0] ybd_reg [SQ];

    logic signed [AW-1:0] ang_u, psi;
    logic [31:0]          h_root;

    // Output register.
    logic               m_valid_reg;
    logic [15:0]        u_out_reg;
    logic signed [17:0] v_out_reg;
    logic               deg_out_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // Mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_mode_reg <= scuv_pkg::MODE_SPHERE;
        end else if (cfg_wr_en) begin
            map_mode_reg <= cfg_wr_data;
        end
    end

    // Valid bits of the front end and the alignment line.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i < SD; i++) begin
                vpipe_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vpipe_reg[0] <= v3_reg;
            for (int i = 1; i < SD; i++) begin
                vpipe_reg[i] <= vpipe_reg[i-1];
            end
        end
    end

    // Stage 1: capture the beat and the mode.
    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg    <= s_tdata[31:0];
            y1_reg    <= s_tdata[63:32];
            z1_reg    <= s_tdata[95:64];
            mode1_reg <= map_mode_reg;
        end
    end

    // Stage 2: magnitudes, normalizing shifts, special cases and cylindrical v.
    always_ff @(posedge aclk) begin
        logic [31:0] mx, my, mz, mu, mv, fr;
        logic [16:0] f17;
        mx = scuv_pkg::mag32(x1_reg);
        my = scuv_pkg::mag32(y1_reg);
        mz = scuv_pkg::mag32(z1_reg);
        mu = (mx > mz) ? mx : mz;
        mv = (my > mu) ? my : mu;
        fr = my & ((32'd1 << scuv_pkg::FRAC_BITS) - 32'd1);
        f17 = 17'((fr >> scuv_pkg::CYL_RS) << scuv_pkg::CYL_LS);
        if (en) begin
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            z2_reg  <= z1_reg;
            su2_reg <= scuv_pkg::norm_shift(mu);
            sv2_reg <= scuv_pkg::norm_shift(mv);
            side2_reg.mode   <= mode1_reg;
            side2_reg.x_zero <= (x1_reg == '0);
            side2_reg.origin <= (x1_reg == '0) && (y1_reg == '0) && (z1_reg == '0);
            side2_reg.z_neg  <= z1_reg[31];
            side2_reg.cyl_v  <= y1_reg[31] ? -$signed({1'b0, f17}) : $signed({1'b0, f17});
        end
    end

    // Stage 3: scale operands, fold the u vector into the right half plane.
    always_ff @(posedge aclk) begin
        logic signed [CW-1:0] az, bx;
        logic signed [31:0]   yn;
        az = CW'(z2_reg) <<< (6'(su2_reg) + 6'(scuv_pkg::PRE_SHIFT));
        bx = CW'(x2_reg) <<< (6'(su2_reg) + 6'(scuv_pkg::PRE_SHIFT));
        yn = y2_reg <<< sv2_reg;
        if (en) begin
            ua3_reg   <= side2_reg.z_neg ? -az : az;
            ub3_reg   <= side2_reg.z_neg ? -bx : bx;
            xn3_reg   <= x2_reg <<< sv2_reg;
            zn3_reg   <= z2_reg <<< sv2_reg;
            yb3_reg   <= CW'(yn) <<< scuv_pkg::PRE_SHIFT;
            side3_reg <= side2_reg;
        end
    end

    // Stage 4 and 5: squared horizontal radius.
    always_ff @(posedge aclk) begin
        if (en) begin
            sqx4_reg <= 64'(xn3_reg * xn3_reg);
            sqz4_reg <= 64'(zn3_reg * zn3_reg);
            yb4_reg  <= yb3_reg;
            n5_reg   <= sqx4_reg + sqz4_reg;
            yb5_reg  <= yb4_reg;
        end
    end

    // u angle from (z, x).
    scuv_cordic u_cordic (
        .aclk  (aclk),
        .en    (en),
        .a_in  (ua3_reg),
        .b_in  (ub3_reg),
        .angle (ang_u)
    );

    // Horizontal radius for the elevation angle.
    scuv_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .n_in (n5_reg),
        .root (h_root)
    );

    // Elevation angle from (h, y).
    scuv_cordic v_cordic (
        .aclk  (aclk),
        .en    (en),
        .a_in  (CW'({1'b0, h_root}) <<< scuv_pkg::PRE_SHIFT),
        .b_in  (ybd_reg[SQ-1]),
        .angle (psi)
    );

    // Alignment lines for flags, the u angle and the y operand.
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0]   <= side3_reg;
            ualign_reg[0] <= ang_u;
            ybd_reg[0]    <= yb5_reg;
            for (int i = 1; i < SD; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 1; i < UA; i++) begin
                ualign_reg[i] <= ualign_reg[i-1];
            end
            for (int i = 1; i < SQ; i++) begin
                ybd_reg[i] <= ybd_reg[i-1];
            end
        end
    end

    // Output stage: finish u and v, pick the mode, and hold until taken.
    always_ff @(posedge aclk) begin
        side_t                sd;
        logic signed [AW-1:0] t, utw;
        logic [16:0]          u17;
        logic signed [AW:0]   w, q, vs;
        sd  = side_reg[SD-1];
        t   = (sd.z_neg ? AW'(34'sh80000000) : '0) + (sd.x_zero ? '0 : ualign_reg[UA-1]);
        utw = AW'(34'sh80000000) - t;
        u17 = {1'b0, utw[31:16]} + 17'(utw[15]);
        w   = (AW + 1)'(psi) + (AW + 1)'(16384);
        q   = w >>> 15;
        vs  = q + (AW + 1)'(32768);
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vpipe_reg[SD-1];
        end
        if (en) begin
            deg_out_reg <= 1'b0;
            if (sd.mode == scuv_pkg::MODE_CYL) begin
                u_out_reg <= u17[16] ? 16'hFFFF : u17[15:0];
                v_out_reg <= sd.cyl_v;
            end else if (sd.origin) begin
                u_out_reg   <= 16'd32768;
                v_out_reg   <= 18'sd32768;
                deg_out_reg <= 1'b1;
            end else begin
                u_out_reg <= u17[16] ? 16'hFFFF : u17[15:0];
                if (vs < 0) begin
                    v_out_reg <= '0;
                end else if (vs > (AW + 1)'(65536)) begin
                    v_out_reg <= 18'sd65536;
                end else begin
                    v_out_reg <= vs[17:0];
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, v_out_reg, u_out_reg};
    assign m_tuser  = deg_out_reg;

endmodule
